// File: sv/bct_pkg.sv
// Shared types, character codes and sizes of the bencode token parser.
`default_nettype none

package bct_pkg;

	localparam int MAX_DEPTH = 32;
	localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);
	localparam int IDX_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

	localparam logic [7:0] CH_D     = 8'h64;
	localparam logic [7:0] CH_L     = 8'h6C;
	localparam logic [7:0] CH_I     = 8'h69;
	localparam logic [7:0] CH_E     = 8'h65;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [30:0] LEN_LIMIT = 31'h7FFF_FFFF;
	localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

	typedef enum logic [2:0] {
		EV_DICT_OPEN = 3'd0,
		EV_LIST_OPEN = 3'd1,
		EV_CLOSE     = 3'd2,
		EV_INTEGER   = 3'd3,
		EV_STR_HDR   = 3'd4,
		EV_NULL      = 3'd5,
		EV_STR_BYTE  = 3'd6,
		EV_ERROR     = 3'd7
	} ev_kind_t;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_NO_LEN    = 3'd1,
		ERR_NO_COLON  = 3'd2,
		ERR_NO_DIGITS = 3'd3,
		ERR_NO_E      = 3'd4,
		ERR_TOO_DEEP  = 3'd5,
		ERR_OVERFLOW  = 3'd6
	} err_code_t;

	typedef struct packed {
		ev_kind_t         kind;
		logic [63:0]      ival;
		logic [30:0]      slen;
		logic [7:0]       data;
		logic             key;
		logic             last;
		logic             text;
		logic [DEPTH_W-1:0] depth;
		logic             done;
		err_code_t        code;
	} event_t;

endpackage

`default_nettype wire

// File: sv/bencode_token_parser.sv
// Top level of the bencode token parser: input register, parser core, event register.
//
//  channel | valid       | stall       | payload
//  byte    | byte_valid  | byte_stall  | byte_value, start_document
//  event   | event_valid | event_stall | event_kind .. error_code
//
// One byte is parsed per clock unless stalled; the outputs come from the event register.
// The whole per-byte step sits between the input register and the event register.
// Reset clears the control state; the container stack holds no reset value.
// A stalled event register holds the input register, which then stalls the byte side.
`default_nettype none

module bencode_token_parser (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        byte_valid,
	output logic                             byte_stall,
	input  wire logic [7:0]                  byte_value,
	input  wire logic                        start_document,
	output logic                             event_valid,
	input  wire logic                        event_stall,
	output logic [2:0]                       event_kind,
	output logic signed [63:0]               int_value,
	output logic [30:0]                      string_length,
	output logic [7:0]                       data_byte,
	output logic                             is_key,
	output logic                             last_byte,
	output logic                             text_valid,
	output logic [bct_pkg::DEPTH_W-1:0]      nest_depth,
	output logic                             document_done,
	output logic [2:0]                       error_code
);

	logic            valid_s1;
	logic [7:0]      byte_s1;
	logic            start_s1;
	logic            adv;
	logic            fire;
	logic            emit;
	bct_pkg::event_t ev;
	logic            ev_valid_q;
	bct_pkg::event_t ev_q;

	assign adv        = !ev_valid_q || !event_stall;
	assign byte_stall = valid_s1 && !adv;
	assign fire       = valid_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			byte_s1  <= byte_value;
			start_s1 <= start_document;
		end
	end

	bct_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.byte_in  (byte_s1),
		.start_in (start_s1),
		.emit     (emit),
		.ev       (ev)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_valid_q <= 1'b0;
		end else if (adv) begin
			ev_valid_q <= fire && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			ev_q <= ev;
		end
	end

	assign event_valid   = ev_valid_q;
	assign event_kind    = ev_q.kind;
	assign int_value     = ev_q.ival;
	assign string_length = ev_q.slen;
	assign data_byte     = ev_q.data;
	assign is_key        = ev_q.key;
	assign last_byte     = ev_q.last;
	assign text_valid    = ev_q.text;
	assign nest_depth    = ev_q.depth;
	assign document_done = ev_q.done;
	assign error_code    = ev_q.code;

`ifndef NO_ASSERTIONS
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		(event_valid && event_kind == bct_pkg::EV_ERROR) |-> (error_code != bct_pkg::ERR_NONE))
		else $error("error event without a code");
	a_ok_code: assert property (@(posedge clk) disable iff (!arst_n)
		(event_valid && event_kind != bct_pkg::EV_ERROR) |-> (error_code == bct_pkg::ERR_NONE))
		else $error("code on a non-error event");
	a_text_last: assert property (@(posedge clk) disable iff (!arst_n)
		(event_valid && text_valid) |-> (last_byte && !is_key))
		else $error("text flag away from the last value byte");
`endif

endmodule

`default_nettype wire

// File: sv/bct_core.sv
// Parser state and the per-byte step that turns one byte into at most one event.
`default_nettype none

module bct_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          fire,
	input  wire logic [7:0]    byte_in,
	input  wire logic          start_in,
	output logic               emit,
	output bct_pkg::event_t    ev
);

	typedef enum logic [7:0] {
		PH_VALUE      = 8'b0000_0001,
		PH_KEY        = 8'b0000_0010,
		PH_LEN        = 8'b0000_0100,
		PH_BYTES      = 8'b0000_1000,
		PH_INT_START  = 8'b0001_0000,
		PH_INT_NEG    = 8'b0010_0000,
		PH_INT_DIGITS = 8'b0100_0000,
		PH_DONE       = 8'b1000_0000
	} phase_t;

	phase_t                        phase_q, ph, ph_n;
	logic [63:0]                   acc_q, acc, acc_n;
	logic                          neg_q, neg, neg_n;
	logic [30:0]                   rem_q, rem, rem_n;
	logic                          key_q, key, key_n;
	logic [1:0]                    ucnt_q, ucnt, ucnt_n;
	logic [2:0]                    ucls_q, ucls, ucls_n;
	logic                          uok_q, uok, uok_n;
	logic [bct_pkg::DEPTH_W-1:0]   dep_q, dep, dep_n;
	logic                          top_q, top, top_n;
	bct_pkg::err_code_t            err_q, err, err_n;
	logic                          stack_q [bct_pkg::MAX_DEPTH];
	logic                          push;
	logic [bct_pkg::DEPTH_W-1:0]   dep_m2;
	logic                          below;
	logic                          digit;
	logic [3:0]                    dval;
	logic [67:0]                   prod;
	logic [63:0]                   limit;
	logic [7:0]                    lo, hi;

	// Stack entries hold 0 for a dictionary and 1 for a list; the top is kept in top_q.
	always_comb begin
		ph   = start_in ? PH_VALUE : phase_q;
		acc  = start_in ? 64'd0 : acc_q;
		neg  = start_in ? 1'b0 : neg_q;
		rem  = start_in ? 31'd0 : rem_q;
		key  = start_in ? 1'b0 : key_q;
		ucnt = start_in ? 2'd0 : ucnt_q;
		ucls = start_in ? 3'd0 : ucls_q;
		uok  = start_in ? 1'b1 : uok_q;
		dep  = start_in ? '0 : dep_q;
		top  = start_in ? 1'b1 : top_q;
		err  = start_in ? bct_pkg::ERR_NONE : err_q;

		digit  = (byte_in >= bct_pkg::CH_ZERO) && (byte_in <= bct_pkg::CH_NINE);
		dval   = digit ? 4'(byte_in - bct_pkg::CH_ZERO) : 4'd0;
		prod   = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + 68'(dval);
		dep_m2 = dep - bct_pkg::DEPTH_W'(2);
		below  = stack_q[dep_m2[bct_pkg::IDX_W-1:0]];
		limit  = neg ? bct_pkg::NEG_LIMIT : bct_pkg::POS_LIMIT;
		lo     = 8'h80;
		hi     = 8'hBF;

		ph_n = ph; acc_n = acc; neg_n = neg; rem_n = rem; key_n = key;
		ucnt_n = ucnt; ucls_n = ucls; uok_n = uok; dep_n = dep; top_n = top;
		err_n = err; push = 1'b0; emit = 1'b0;
		ev = '0;
		ev.kind = bct_pkg::EV_ERROR;
		ev.code = bct_pkg::ERR_NONE;

		if (err == bct_pkg::ERR_NONE) begin
			case (ph)
				PH_VALUE, PH_KEY: begin
					if (ph == PH_VALUE && (byte_in == bct_pkg::CH_D || byte_in == bct_pkg::CH_L)) begin
						if (dep >= bct_pkg::DEPTH_W'(bct_pkg::MAX_DEPTH)) begin
							err_n = bct_pkg::ERR_TOO_DEEP;
							emit = 1'b1;
							ev.code = bct_pkg::ERR_TOO_DEEP;
						end else begin
							push = 1'b1;
							top_n = (byte_in == bct_pkg::CH_L);
							dep_n = dep + bct_pkg::DEPTH_W'(1);
							ph_n = (byte_in == bct_pkg::CH_L) ? PH_VALUE : PH_KEY;
							emit = 1'b1;
							ev.kind = (byte_in == bct_pkg::CH_L) ? bct_pkg::EV_LIST_OPEN
								: bct_pkg::EV_DICT_OPEN;
						end
					end else if (ph == PH_VALUE && byte_in == bct_pkg::CH_I) begin
						acc_n = '0;
						neg_n = 1'b0;
						ph_n = PH_INT_START;
					end else if (byte_in == bct_pkg::CH_E &&
						(ph == PH_KEY || (dep != '0 && top))) begin
						dep_n = dep - bct_pkg::DEPTH_W'(1);
						emit = 1'b1;
						ev.kind = bct_pkg::EV_CLOSE;
						if (dep_n == '0) begin
							ph_n = PH_DONE;
							ev.done = 1'b1;
						end else begin
							top_n = below;
							ph_n = below ? PH_VALUE : PH_KEY;
						end
					end else if (digit) begin
						acc_n = 64'(dval);
						key_n = (ph == PH_KEY);
						ph_n = PH_LEN;
					end else begin
						err_n = bct_pkg::ERR_NO_LEN;
						emit = 1'b1;
						ev.code = bct_pkg::ERR_NO_LEN;
					end
				end
				PH_LEN: begin
					if (digit) begin
						if (prod > 68'(bct_pkg::LEN_LIMIT)) begin
							err_n = bct_pkg::ERR_OVERFLOW;
							emit = 1'b1;
							ev.code = bct_pkg::ERR_OVERFLOW;
						end else begin
							acc_n = prod[63:0];
						end
					end else if (byte_in != bct_pkg::CH_COLON) begin
						err_n = bct_pkg::ERR_NO_COLON;
						emit = 1'b1;
						ev.code = bct_pkg::ERR_NO_COLON;
					end else begin
						rem_n = acc[30:0];
						ucnt_n = 2'd0;
						ucls_n = 3'd0;
						uok_n = 1'b1;
						emit = 1'b1;
						if (acc[30:0] == '0) begin
							if (key) begin
								ph_n = PH_VALUE;
								ev.kind = bct_pkg::EV_STR_HDR;
								ev.key = 1'b1;
							end else begin
								ev.kind = bct_pkg::EV_NULL;
								if (dep == '0) begin
									ph_n = PH_DONE;
									ev.done = 1'b1;
								end else begin
									ph_n = top ? PH_VALUE : PH_KEY;
								end
							end
						end else begin
							ph_n = PH_BYTES;
							ev.kind = bct_pkg::EV_STR_HDR;
							ev.slen = acc[30:0];
							ev.key = key;
						end
					end
				end
				PH_BYTES: begin
					// Strict UTF-8 tracking: count of continuation bytes due and the
					// range class of the next one.
					if (!key && uok) begin
						if (ucnt == 2'd0) begin
							if (byte_in < 8'h80) begin
								ucls_n = 3'd0;
							end else if (byte_in >= 8'hC2 && byte_in <= 8'hDF) begin
								ucnt_n = 2'd1; ucls_n = 3'd0;
							end else if (byte_in == 8'hE0) begin
								ucnt_n = 2'd2; ucls_n = 3'd1;
							end else if (byte_in == 8'hED) begin
								ucnt_n = 2'd2; ucls_n = 3'd2;
							end else if (byte_in >= 8'hE1 && byte_in <= 8'hEF) begin
								ucnt_n = 2'd2; ucls_n = 3'd0;
							end else if (byte_in == 8'hF0) begin
								ucnt_n = 2'd3; ucls_n = 3'd3;
							end else if (byte_in >= 8'hF1 && byte_in <= 8'hF3) begin
								ucnt_n = 2'd3; ucls_n = 3'd0;
							end else if (byte_in == 8'hF4) begin
								ucnt_n = 2'd3; ucls_n = 3'd4;
							end else begin
								uok_n = 1'b0;
							end
						end else begin
							case (ucls)
								3'd1: lo = 8'hA0;
								3'd2: hi = 8'h9F;
								3'd3: lo = 8'h90;
								3'd4: hi = 8'h8F;
								default: lo = 8'h80;
							endcase
							if (byte_in < lo || byte_in > hi) begin
								uok_n = 1'b0;
							end else begin
								ucnt_n = ucnt - 2'd1;
								ucls_n = 3'd0;
							end
						end
					end
					emit = 1'b1;
					ev.kind = bct_pkg::EV_STR_BYTE;
					ev.data = byte_in;
					ev.key = key;
					if (rem > 31'd1) begin
						rem_n = rem - 31'd1;
					end else begin
						rem_n = '0;
						ev.last = 1'b1;
						if (key) begin
							ph_n = PH_VALUE;
						end else begin
							ev.text = uok_n && (ucnt_n == 2'd0);
							if (dep == '0) begin
								ph_n = PH_DONE;
								ev.done = 1'b1;
							end else begin
								ph_n = top ? PH_VALUE : PH_KEY;
							end
						end
					end
				end
				PH_INT_START, PH_INT_NEG, PH_INT_DIGITS: begin
					if (ph == PH_INT_START && byte_in == bct_pkg::CH_MINUS) begin
						neg_n = 1'b1;
						ph_n = PH_INT_NEG;
					end else if (digit) begin
						if (prod > 68'(limit)) begin
							err_n = bct_pkg::ERR_OVERFLOW;
							emit = 1'b1;
							ev.code = bct_pkg::ERR_OVERFLOW;
						end else begin
							acc_n = prod[63:0];
							ph_n = PH_INT_DIGITS;
						end
					end else if (ph != PH_INT_DIGITS) begin
						err_n = bct_pkg::ERR_NO_DIGITS;
						emit = 1'b1;
						ev.code = bct_pkg::ERR_NO_DIGITS;
					end else if (byte_in != bct_pkg::CH_E) begin
						err_n = bct_pkg::ERR_NO_E;
						emit = 1'b1;
						ev.code = bct_pkg::ERR_NO_E;
					end else begin
						emit = 1'b1;
						ev.kind = bct_pkg::EV_INTEGER;
						ev.ival = neg ? (64'd0 - acc) : acc;
						if (dep == '0) begin
							ph_n = PH_DONE;
							ev.done = 1'b1;
						end else begin
							ph_n = top ? PH_VALUE : PH_KEY;
						end
					end
				end
				default: begin
					ph_n = ph;
				end
			endcase
		end
		ev.depth = dep_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_VALUE;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			rem_q   <= '0;
			key_q   <= 1'b0;
			ucnt_q  <= 2'd0;
			ucls_q  <= 3'd0;
			uok_q   <= 1'b1;
			dep_q   <= '0;
			top_q   <= 1'b1;
			err_q   <= bct_pkg::ERR_NONE;
		end else if (fire) begin
			phase_q <= ph_n;
			acc_q   <= acc_n;
			neg_q   <= neg_n;
			rem_q   <= rem_n;
			key_q   <= key_n;
			ucnt_q  <= ucnt_n;
			ucls_q  <= ucls_n;
			uok_q   <= uok_n;
			dep_q   <= dep_n;
			top_q   <= top_n;
			err_q   <= err_n;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && push) begin
			stack_q[dep[bct_pkg::IDX_W-1:0]] <= top_n;
		end
	end

`ifndef NO_ASSERTIONS
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dep_q <= bct_pkg::DEPTH_W'(bct_pkg::MAX_DEPTH))
		else $error("open depth beyond the stack size");
	a_err_event: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && emit && ev.kind == bct_pkg::EV_ERROR) |=> (err_q != bct_pkg::ERR_NONE))
		else $error("error event did not latch an error");
	a_utf8_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(ucnt_q == 2'd0) |-> (ucls_q == 3'd0))
		else $error("UTF-8 range class set with no continuation due");
`endif

endmodule

`default_nettype wire
